FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the named byte FIFO.
// Depends on nothing; include it with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/nmcbf_pkg.sv
// Package of the named multi-channel byte FIFO: field widths, codes, defaults
// and the control structs between the sequencer and the name table.
// Depends on nothing.
`timescale 1ns / 1ps

package nmcbf_pkg;

    // Default geometry.
    localparam int NUM_PIPES_DEF  = 16;
    localparam int PIPE_DEPTH_DEF = 256;

    // Fixed field widths of the channels.
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 4;
    localparam int KEY_W    = 64;
    localparam int BYTE_W   = 8;
    localparam int PID_W    = 16;
    localparam int STATUS_W = 3;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 3'd0,
        CMD_OPEN   = 3'd1,
        CMD_CLOSE  = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_NOFREE  = 3'd3,
        ST_REFUSED = 3'd4
    } status_t;

    // Updates requested from the name table.
    typedef struct packed {
        logic claim;
        logic free_pipe;
    } name_ctl_t;

    // Outcome of the name table scan.
    typedef struct packed {
        logic match_hit;
        logic free_hit;
    } scan_t;

endpackage

FILE: rtl/nmcbf_cmd_if.sv
// Command channel of the named byte FIFO: valid/ready plus one command item.
// Depends on nmcbf_pkg.
`timescale 1ns / 1ps

interface nmcbf_cmd_if import nmcbf_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  pipe_index;
    logic [KEY_W-1:0]  name_key;
    logic [BYTE_W-1:0] data_byte;
    logic [PID_W-1:0]  requester_pid;
    logic              transfer_end;

    modport source (
        output valid, cmd, pipe_index, name_key, data_byte, requester_pid, transfer_end,
        input  ready
    );

    modport sink (
        input  valid, cmd, pipe_index, name_key, data_byte, requester_pid, transfer_end,
        output ready
    );

endinterface

FILE: rtl/nmcbf_rsp_if.sv
// Response channel of the named byte FIFO: valid/ready plus one result item.
// Depends on nmcbf_pkg.
`timescale 1ns / 1ps

interface nmcbf_rsp_if import nmcbf_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    result_pipe;
    logic [BYTE_W-1:0]   read_byte;
    logic                wake_other_side;

    modport source (
        output valid, status, result_pipe, read_byte, wake_other_side,
        input  ready
    );

    modport sink (
        input  valid, status, result_pipe, read_byte, wake_other_side,
        output ready
    );

endinterface

FILE: rtl/nmcbf_name_table.sv
// Name table: per-pipe used flags and 64-bit name keys, with a parallel
// match search and a lowest-free search. Depends on nmcbf_pkg.
`timescale 1ns / 1ps

module nmcbf_name_table
    import nmcbf_pkg::*;
#(
    parameter int NUM_PIPES = NUM_PIPES_DEF,
    parameter int PW        = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] key,
    input  name_ctl_t        ctl,
    input  logic [PW-1:0]    free_idx_in,
    output scan_t            scan,
    output logic [PW-1:0]    match_idx,
    output logic [PW-1:0]    free_idx
);

    logic [NUM_PIPES-1:0] in_use_reg;
    logic [KEY_W-1:0]     name_reg [NUM_PIPES];
    logic [NUM_PIPES-1:0] match_vec;

    // Compare every used entry against the key.
    always_comb
    begin
        for (int i = 0; i < NUM_PIPES; i++)
        begin
            match_vec[i] = in_use_reg[i] && (name_reg[i] == key);
        end
    end

    // Lowest-index match and lowest-index free entry.
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_idx = PW'(i);
            end
            if (!in_use_reg[i])
            begin
                free_idx = PW'(i);
            end
        end
        scan.match_hit = |match_vec;
        scan.free_hit  = ~&in_use_reg;
    end

    // Used flags: a claim takes the free entry, a release frees the given one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
        end
        else if (ctl.claim)
        begin
            in_use_reg[free_idx] <= 1'b1;
        end
        else if (ctl.free_pipe)
        begin
            in_use_reg[free_idx_in] <= 1'b0;
        end
    end

    // Name keys are only read where the used flag is set.
    always_ff @(posedge clk)
    begin
        if (ctl.claim)
        begin
            name_reg[free_idx] <= key;
        end
    end

endmodule

FILE: rtl/nmcbf_desc_mem.sv
// Pipe descriptor memory: read pointer, write pointer, fill count and owner
// per pipe, registered synchronous read, with per-entry valid bits so that an
// entry never written reads as zero. Depends on nmcbf_pkg.
`timescale 1ns / 1ps

module nmcbf_desc_mem
    import nmcbf_pkg::*;
#(
    parameter int NUM_PIPES = NUM_PIPES_DEF,
    parameter int PW        = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1,
    parameter int PTR_W     = 8,
    parameter int FILL_W    = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [PW-1:0]     rd_addr,
    output logic [PTR_W-1:0]  rd_rptr,
    output logic [PTR_W-1:0]  rd_wptr,
    output logic [FILL_W-1:0] rd_fill,
    output logic [PID_W-1:0]  rd_owner,
    input  logic              wr_en,
    input  logic [PW-1:0]     wr_addr,
    input  logic [PTR_W-1:0]  wr_rptr,
    input  logic [PTR_W-1:0]  wr_wptr,
    input  logic [FILL_W-1:0] wr_fill,
    input  logic [PID_W-1:0]  wr_owner
);

    localparam int DW = 2 * PTR_W + FILL_W + PID_W;

    logic [DW-1:0]        mem [NUM_PIPES];
    logic [NUM_PIPES-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic [DW-1:0]        rd_word_reg;
    logic [DW-1:0]        rd_word;

    // Memory array: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_rptr, wr_wptr, wr_fill, wr_owner};
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // Valid bits and the valid flag captured with the read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // An entry never written reads as its reset value of zero.
    assign rd_word = rd_valid_reg ? rd_word_reg : '0;
    assign {rd_rptr, rd_wptr, rd_fill, rd_owner} = rd_word;

endmodule

FILE: rtl/nmcbf_byte_mem.sv
// Byte store shared by all pipes: one write port and one read port with the
// read data registered. Depends on nmcbf_pkg.
`timescale 1ns / 1ps

module nmcbf_byte_mem
    import nmcbf_pkg::*;
#(
    parameter int AW    = 12,
    parameter int DEPTH = 4096
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/named_multi_channel_byte_fifo_core.sv
// Channel | Role    | Carries
// cmd_ch  | sink    | cmd, pipe_index, name_key, data_byte, requester_pid, transfer_end
// rsp_ch  | source  | status, result_pipe, read_byte, wake_other_side
//
// One command is in flight at a time. A command is accepted in the idle
// state and runs in the execute state on the descriptor read at accept; a
// successful read then waits in the read state for the byte memory read.
// Reset is asynchronous and needs no clearing pass: descriptor entries carry
// valid bits and the byte store is only read where it was written.
// A stalled response holds in the output register; the next command is still
// accepted and waits in its execute cycle until the output register frees.
//
// Top level of the named byte FIFO: command sequencer around the name table,
// descriptor memory and byte memory. Depends on nmcbf_pkg and both channel
// interfaces.
`timescale 1ns / 1ps

module named_multi_channel_byte_fifo_core
    import nmcbf_pkg::*;
#(
    parameter int NUM_PIPES  = NUM_PIPES_DEF,
    parameter int PIPE_DEPTH = PIPE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    nmcbf_cmd_if.sink          cmd_ch,
    nmcbf_rsp_if.source        rsp_ch
);

    localparam int PW         = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PTR_W      = $clog2(PIPE_DEPTH);
    localparam int FILL_W     = $clog2(PIPE_DEPTH + 1);
    localparam int BYTE_AW    = PW + PTR_W;
    localparam int BYTE_DEPTH = NUM_PIPES * (1 << PTR_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t              state_reg, state_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [IDX_W-1:0]    rsp_pipe_reg, rsp_pipe_next;
    logic [BYTE_W-1:0]   rsp_byte_reg, rsp_byte_next;
    logic                rsp_wake_reg, rsp_wake_next;

    // Latched command.
    logic [CMD_W-1:0]  cmd_reg;
    logic [PW-1:0]     idx_reg;
    logic              oor_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [PID_W-1:0]  pid_reg;
    logic              tend_reg;

    logic accept;
    logic slot_free;
    logic fire;

    // Name table links.
    name_ctl_t     name_ctl;
    scan_t         scan;
    logic [PW-1:0] match_idx;
    logic [PW-1:0] free_idx;

    // Descriptor memory links.
    logic [PTR_W-1:0]  d_rptr, d_wptr;
    logic [FILL_W-1:0] d_fill;
    logic [PID_W-1:0]  d_owner;
    logic              desc_wr_en;
    logic [PW-1:0]     desc_wr_addr;
    logic [PTR_W-1:0]  w_rptr, w_wptr;
    logic [FILL_W-1:0] w_fill;
    logic [PID_W-1:0]  w_owner;

    // Byte memory links.
    logic                byte_wr_en;
    logic                byte_rd_en;
    logic [BYTE_AW-1:0]  byte_rd_addr;
    logic [BYTE_W-1:0]   byte_rd_data;

    // Execute-cycle decisions.
    logic                read_ok;
    logic [STATUS_W-1:0] ex_status;
    logic [IDX_W-1:0]    ex_pipe;
    logic                ex_wake;

    function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(PIPE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign cmd_ch.ready = (state_reg == S_IDLE);
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign slot_free    = !rsp_valid_reg || rsp_ch.ready;
    assign fire         = (state_reg == S_EXEC) && slot_free;

    // Capture the command on its transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_ch.cmd;
            idx_reg  <= PW'(cmd_ch.pipe_index);
            oor_reg  <= (int'(cmd_ch.pipe_index) >= NUM_PIPES);
            key_reg  <= cmd_ch.name_key;
            data_reg <= cmd_ch.data_byte;
            pid_reg  <= cmd_ch.requester_pid;
            tend_reg <= cmd_ch.transfer_end;
        end
    end

    nmcbf_name_table #(
        .NUM_PIPES (NUM_PIPES),
        .PW        (PW)
    ) u_name_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         (key_reg),
        .ctl         (name_ctl),
        .free_idx_in (idx_reg),
        .scan        (scan),
        .match_idx   (match_idx),
        .free_idx    (free_idx)
    );

    nmcbf_desc_mem #(
        .NUM_PIPES (NUM_PIPES),
        .PW        (PW),
        .PTR_W     (PTR_W),
        .FILL_W    (FILL_W)
    ) u_desc_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (PW'(cmd_ch.pipe_index)),
        .rd_rptr  (d_rptr),
        .rd_wptr  (d_wptr),
        .rd_fill  (d_fill),
        .rd_owner (d_owner),
        .wr_en    (desc_wr_en),
        .wr_addr  (desc_wr_addr),
        .wr_rptr  (w_rptr),
        .wr_wptr  (w_wptr),
        .wr_fill  (w_fill),
        .wr_owner (w_owner)
    );

    nmcbf_byte_mem #(
        .AW    (BYTE_AW),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_mem (
        .clk     (clk),
        .wr_en   (byte_wr_en),
        .wr_addr ({idx_reg, d_wptr}),
        .wr_data (data_reg),
        .rd_en   (byte_rd_en),
        .rd_addr (byte_rd_addr),
        .rd_data (byte_rd_data)
    );

    assign byte_rd_addr = {idx_reg, d_rptr};

    // Execute one command against the descriptor read in the accept cycle.
    always_comb
    begin
        name_ctl     = '0;
        desc_wr_en   = 1'b0;
        desc_wr_addr = idx_reg;
        w_rptr       = d_rptr;
        w_wptr       = d_wptr;
        w_fill       = d_fill;
        w_owner      = d_owner;
        byte_wr_en   = 1'b0;
        byte_rd_en   = 1'b0;
        read_ok      = 1'b0;
        ex_status    = ST_OK;
        ex_pipe      = '0;
        ex_wake      = 1'b0;
        case (cmd_reg)
            CMD_CREATE, CMD_OPEN:
            begin
                if ((cmd_reg == CMD_OPEN) && scan.match_hit)
                begin
                    ex_pipe = IDX_W'(match_idx);
                end
                else if (scan.free_hit)
                begin
                    name_ctl.claim = fire;
                    desc_wr_en     = fire;
                    desc_wr_addr   = free_idx;
                    w_rptr         = '0;
                    w_wptr         = '0;
                    w_fill         = '0;
                    w_owner        = pid_reg;
                    ex_pipe        = IDX_W'(free_idx);
                end
                else
                begin
                    ex_status = ST_NOFREE;
                end
            end
            CMD_CLOSE:
            begin
                if (oor_reg || (d_owner != pid_reg))
                begin
                    ex_status = ST_REFUSED;
                end
                else
                begin
                    name_ctl.free_pipe = fire;
                end
            end
            CMD_WRITE:
            begin
                if (oor_reg || (d_fill == FILL_W'(PIPE_DEPTH)))
                begin
                    ex_status = ST_FULL;
                end
                else
                begin
                    byte_wr_en = fire;
                    desc_wr_en = fire;
                    w_wptr     = ptr_step(d_wptr);
                    w_fill     = d_fill + FILL_W'(1);
                    ex_wake    = tend_reg;
                end
            end
            CMD_READ:
            begin
                if (oor_reg || (d_fill == '0))
                begin
                    ex_status = ST_EMPTY;
                end
                else
                begin
                    byte_rd_en = fire;
                    desc_wr_en = fire;
                    w_rptr     = ptr_step(d_rptr);
                    w_fill     = d_fill - FILL_W'(1);
                    read_ok    = 1'b1;
                end
            end
            default:
            begin
                ex_status = ST_OK;
            end
        endcase
    end

    // Sequencer next state and response register loading.
    always_comb
    begin
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ch.ready;
        rsp_status_next = rsp_status_reg;
        rsp_pipe_next   = rsp_pipe_reg;
        rsp_byte_next   = rsp_byte_reg;
        rsp_wake_next   = rsp_wake_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    if (read_ok)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next      = S_IDLE;
                        rsp_valid_next  = 1'b1;
                        rsp_status_next = ex_status;
                        rsp_pipe_next   = ex_pipe;
                        rsp_byte_next   = '0;
                        rsp_wake_next   = ex_wake;
                    end
                end
            end
            S_READ:
            begin
                // The response register was freed when the read was issued.
                state_next      = S_IDLE;
                rsp_valid_next  = 1'b1;
                rsp_status_next = ST_OK;
                rsp_pipe_next   = '0;
                rsp_byte_next   = byte_rd_data;
                rsp_wake_next   = tend_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and response registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= '0;
            rsp_pipe_reg   <= '0;
            rsp_byte_reg   <= '0;
            rsp_wake_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_pipe_reg   <= rsp_pipe_next;
            rsp_byte_reg   <= rsp_byte_next;
            rsp_wake_reg   <= rsp_wake_next;
        end
    end

    assign rsp_ch.valid           = rsp_valid_reg;
    assign rsp_ch.status          = rsp_status_reg;
    assign rsp_ch.result_pipe     = rsp_pipe_reg;
    assign rsp_ch.read_byte       = rsp_byte_reg;
    assign rsp_ch.wake_other_side = rsp_wake_reg;

endmodule

FILE: rtl/nmcbf_checker.sv
// Port checker for the named byte FIFO, bound to the top level.
// Depends on nmcbf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nmcbf_checker
    import nmcbf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [IDX_W-1:0]    result_pipe,
    input logic [BYTE_W-1:0]   read_byte,
    input logic                wake_other_side
);

    // A stalled response keeps its valid and its status.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status))

    // Only one command is in flight: ready drops after each transfer.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    // A refused or failed command carries no byte and no wake.
    `ASSERT_IMPLY(a_error_quiet, clk, rst_n, rsp_valid && (status != ST_OK), (read_byte == '0) && !wake_other_side)

    // A pipe index is only reported with an ok status.
    `ASSERT_IMPLY(a_pipe_only_ok, clk, rst_n, rsp_valid && (status != ST_OK), result_pipe == '0)

endmodule

bind named_multi_channel_byte_fifo_core nmcbf_checker u_nmcbf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_ch.valid),
    .cmd_ready       (cmd_ch.ready),
    .rsp_valid       (rsp_ch.valid),
    .rsp_ready       (rsp_ch.ready),
    .status          (rsp_ch.status),
    .result_pipe     (rsp_ch.result_pipe),
    .read_byte       (rsp_ch.read_byte),
    .wake_other_side (rsp_ch.wake_other_side)
);

FILE: tb/sv/nmcbf_tb_pkg.sv
// Testbench package of the named byte FIFO: transfer structs and the scoreboard
// that predicts each response and compares it. Depends on nmcbf_pkg.
`timescale 1ns / 1ps

package nmcbf_tb_pkg;

    import nmcbf_pkg::*;

    localparam int NPIPES = NUM_PIPES_DEF;
    localparam int DEPTH  = PIPE_DEPTH_DEF;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH) + 1;

    // Command codes that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_RESERVED_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RESERVED_C = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  pipe_index;
        logic [KEY_W-1:0]  name_key;
        logic [BYTE_W-1:0] data_byte;
        logic [PID_W-1:0]  requester_pid;
        logic              transfer_end;
    } command_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    result_pipe;
        logic [BYTE_W-1:0]   read_byte;
        logic                wake_other_side;
    } response_t;

    class byte_fifo_scoreboard;

        // Shadow copy of the pipe table and the ring buffers.
        bit              in_use   [NPIPES];
        bit [PTR_W-1:0]  rd_ptr   [NPIPES];
        bit [PTR_W-1:0]  wr_ptr   [NPIPES];
        bit [FILL_W-1:0] fill     [NPIPES];
        bit [PID_W-1:0]  owner    [NPIPES];
        bit [KEY_W-1:0]  pipe_key [NPIPES];
        bit [BYTE_W-1:0] ring     [NPIPES][DEPTH];

        response_t pending_results[$];
        int        mismatches;
        int        checked;
        int        status_seen[8];
        int        wakes;

        function bit [PTR_W-1:0] next_slot(bit [PTR_W-1:0] p);
            return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
        endfunction

        // Take the lowest free pipe and set it up fresh; -1 when the table is full.
        function int claim_pipe(bit [KEY_W-1:0] key, bit [PID_W-1:0] pid);
            for (int i = 0; i < NPIPES; i++)
            begin
                if (!in_use[i])
                begin
                    in_use[i]   = 1'b1;
                    pipe_key[i] = key;
                    rd_ptr[i]   = '0;
                    wr_ptr[i]   = '0;
                    fill[i]     = '0;
                    owner[i]    = pid;
                    return i;
                end
            end
            return -1;
        endfunction

        // Apply one command to the shadow table and return its response.
        function response_t execute_command(command_t c);
            response_t r;
            int        hit;
            int        idx;
            r   = '0;
            hit = -1;
            idx = int'(c.pipe_index);
            case (c.cmd)
                CMD_CREATE, CMD_OPEN:
                begin
                    if (c.cmd == CMD_OPEN)
                    begin
                        for (int i = 0; i < NPIPES; i++)
                        begin
                            if (hit < 0 && in_use[i] && pipe_key[i] == c.name_key)
                                hit = i;
                        end
                    end
                    if (hit < 0)
                        hit = claim_pipe(c.name_key, c.requester_pid);
                    if (hit < 0)
                        r.status = ST_NOFREE;
                    else
                        r.result_pipe = hit[IDX_W-1:0];
                end
                CMD_CLOSE:
                begin
                    if (idx >= NPIPES || owner[idx] != c.requester_pid)
                        r.status = ST_REFUSED;
                    else
                        in_use[idx] = 1'b0;
                end
                CMD_WRITE:
                begin
                    if (idx >= NPIPES || int'(fill[idx]) >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        ring[idx][wr_ptr[idx]] = c.data_byte;
                        wr_ptr[idx]            = next_slot(wr_ptr[idx]);
                        fill[idx]              = fill[idx] + 1'b1;
                        r.wake_other_side      = c.transfer_end;
                    end
                end
                CMD_READ:
                begin
                    if (idx >= NPIPES || fill[idx] == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.read_byte       = ring[idx][rd_ptr[idx]];
                        rd_ptr[idx]       = next_slot(rd_ptr[idx]);
                        fill[idx]         = fill[idx] - 1'b1;
                        r.wake_other_side = c.transfer_end;
                    end
                end
                default:
                begin
                    // Reserved codes leave everything alone and answer with zeros.
                end
            endcase
            return r;
        endfunction

        function void note_command(command_t c);
            pending_results.push_back(execute_command(c));
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(response_t got);
            response_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: response with no command outstanding, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("status", want.status, got.status);
            compare_field("result_pipe", want.result_pipe, got.result_pipe);
            compare_field("read_byte", want.read_byte, got.read_byte);
            compare_field("wake_other_side", want.wake_other_side, got.wake_other_side);
            status_seen[got.status]++;
            if (got.wake_other_side)
                wakes++;
        endfunction

    endclass

endpackage

FILE: tb/sv/named_multi_channel_byte_fifo_core_tb.sv
// Regression of the named byte FIFO core: directed and random command streams
// checked against a scoreboard. Depends on nmcbf_pkg, both channel interfaces,
// nmcbf_tb_pkg and the core.
`timescale 1ns / 1ps

module named_multi_channel_byte_fifo_core_tb;

    import nmcbf_pkg::*;
    import nmcbf_tb_pkg::*;

    localparam int ITEMS_TARGET   = 1250;
    localparam int WATCHDOG_LIMIT = 3000;

    logic clk;
    logic rst_n;

    nmcbf_cmd_if cmd_ch ();
    nmcbf_rsp_if rsp_ch ();

    named_multi_channel_byte_fifo_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .rsp_ch (rsp_ch)
    );

    byte_fifo_scoreboard sb = new();

    bit                quiet_phase;
    int                real_items;
    int                total_items;
    int                stall_cycles;
    logic [KEY_W-1:0]  key_pool [8];
    logic [PID_W-1:0]  pid_pool [6];

    // Free-running clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none during quiet phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        return key_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [PID_W-1:0] pick_pid();
        if ($urandom_range(0, 9) == 0)
            return PID_W'($urandom);
        return pid_pool[$urandom_range(0, 5)];
    endfunction

    // Prefer pipes that are in use, but sometimes hit a free one.
    function automatic logic [IDX_W-1:0] pick_pipe();
        int used[$];
        for (int i = 0; i < NPIPES; i++)
        begin
            if (sb.in_use[i])
                used.push_back(i);
        end
        if (used.size() != 0 && $urandom_range(0, 9) < 7)
            return IDX_W'(used[$urandom_range(0, used.size() - 1)]);
        return IDX_W'($urandom_range(0, NPIPES - 1));
    endfunction

    // Present one command and hold it until the transfer completes.
    task automatic send_command(input command_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.cmd           <= c.cmd;
        cmd_ch.pipe_index    <= c.pipe_index;
        cmd_ch.name_key      <= c.name_key;
        cmd_ch.data_byte     <= c.data_byte;
        cmd_ch.requester_pid <= c.requester_pid;
        cmd_ch.transfer_end  <= c.transfer_end;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.note_command(c);
        total_items++;
        if (c.cmd <= CMD_READ)
            real_items++;
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                         input logic [KEY_W-1:0] key, input logic [BYTE_W-1:0] data,
                         input logic [PID_W-1:0] pid, input logic tend);
        command_t c;
        c = '{cmd: cmd, pipe_index: idx, name_key: key, data_byte: data,
              requester_pid: pid, transfer_end: tend};
        send_command(c);
    endtask

    // Hold off the sender until every outstanding response has come back.
    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_results.size() != 0);
    endtask

    // Write a burst into one pipe and read it back, sometimes interleaved.
    task automatic stream_episode();
        logic [IDX_W-1:0] idx;
        int               n;
        int               reads;
        idx = pick_pipe();
        n   = $urandom_range(1, 20);
        if ($urandom_range(0, 2) == 0)
        begin
            for (int k = 0; k < 2 * n; k++)
            begin
                issue($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, idx, pick_key(),
                      BYTE_W'($urandom), pick_pid(), $urandom_range(0, 3) == 0);
            end
        end
        else
        begin
            for (int k = 0; k < n; k++)
                issue(CMD_WRITE, idx, pick_key(), BYTE_W'($urandom), pick_pid(),
                      k == n - 1 || $urandom_range(0, 7) == 0);
            reads = n + $urandom_range(0, 2);
            for (int k = 0; k < reads; k++)
                issue(CMD_READ, idx, pick_key(), BYTE_W'($urandom), pick_pid(),
                      k == reads - 1 || $urandom_range(0, 7) == 0);
        end
    endtask

    // Create, open and close against a small pool of names and owners.
    task automatic table_episode();
        int               n;
        int               r;
        logic [IDX_W-1:0] idx;
        if ($urandom_range(0, 3) == 0)
            key_pool[$urandom_range(2, 7)] = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            pid_pool[$urandom_range(2, 5)] = PID_W'($urandom);
        n = $urandom_range(3, 10);
        for (int k = 0; k < n; k++)
        begin
            r   = $urandom_range(0, 99);
            idx = pick_pipe();
            if (r < 40)
                issue(CMD_OPEN, IDX_W'($urandom), pick_key(), BYTE_W'($urandom),
                      pick_pid(), 1'($urandom));
            else if (r < 60)
                issue(CMD_CREATE, IDX_W'($urandom), pick_key(), BYTE_W'($urandom),
                      pick_pid(), 1'($urandom));
            else if (r < 85)
                issue(CMD_CLOSE, idx, pick_key(), BYTE_W'($urandom), sb.owner[idx],
                      1'($urandom));
            else
                issue(CMD_CLOSE, idx, pick_key(), BYTE_W'($urandom),
                      sb.owner[idx] ^ (16'h1 << $urandom_range(0, PID_W - 1)),
                      1'($urandom));
        end
    endtask

    // Run the table out of free pipes, then release a few.
    task automatic exhaust_episode();
        int               free_cnt;
        logic [IDX_W-1:0] idx;
        free_cnt = 0;
        for (int i = 0; i < NPIPES; i++)
        begin
            if (!sb.in_use[i])
                free_cnt++;
        end
        repeat (free_cnt + $urandom_range(1, 2))
            issue($urandom_range(0, 1) ? CMD_CREATE : CMD_OPEN, IDX_W'($urandom),
                  {$urandom, $urandom}, BYTE_W'($urandom), pick_pid(), 1'($urandom));
        repeat ($urandom_range(2, 6))
        begin
            idx = IDX_W'($urandom_range(0, NPIPES - 1));
            issue(CMD_CLOSE, idx, pick_key(), BYTE_W'($urandom), sb.owner[idx],
                  1'($urandom));
        end
    endtask

    // Fill one pipe past full and drain it past empty; both pointers wrap.
    task automatic fill_episode();
        logic [IDX_W-1:0] idx;
        int               n;
        idx = pick_pipe();
        n   = DEPTH - int'(sb.fill[idx]) + 2;
        for (int k = 0; k < n; k++)
            issue(CMD_WRITE, idx, pick_key(), BYTE_W'($urandom), pick_pid(),
                  k >= n - 3 || $urandom_range(0, 15) == 0);
        n = DEPTH + 2;
        for (int k = 0; k < n; k++)
            issue(CMD_READ, idx, pick_key(), BYTE_W'($urandom), pick_pid(),
                  k >= n - 3 || $urandom_range(0, 15) == 0);
    endtask

    // Fully random commands, reserved codes included.
    task automatic noise_episode();
        repeat ($urandom_range(1, 8))
            issue(CMD_W'($urandom_range(0, 7)), IDX_W'($urandom), {$urandom, $urandom},
                  BYTE_W'($urandom), PID_W'($urandom), 1'($urandom));
    endtask

    // Response side: ready with random stalls.
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Check every response transfer.
    always @(posedge clk)
    begin : rsp_monitor
        response_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status          = rsp_ch.status;
            got.result_pipe     = rsp_ch.result_pipe;
            got.read_byte       = rsp_ch.read_byte;
            got.wake_other_side = rsp_ch.wake_other_side;
            sb.check_response(got);
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                     $time, stall_cycles, sb.pending_results.size());
            $display("named_multi_channel_byte_fifo_core regression: fail");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        bit fill_done;
        int r;
        fill_done            = 1'b0;
        quiet_phase          = 1'b0;
        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.cmd           = '0;
        cmd_ch.pipe_index    = '0;
        cmd_ch.name_key      = '0;
        cmd_ch.data_byte     = '0;
        cmd_ch.requester_pid = '0;
        cmd_ch.transfer_end  = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            key_pool[i] = {$urandom, $urandom};
        pid_pool[0] = '0;
        pid_pool[1] = '1;
        for (int i = 2; i < 6; i++)
            pid_pool[i] = PID_W'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty read and close on a free pipe straight after reset.
        issue(CMD_READ, 4'd0, '0, '0, '0, 1'b1);
        issue(CMD_CLOSE, 4'd3, '0, '0, 16'h0000, 1'b0);
        issue(CMD_CLOSE, 4'd3, '1, '1, 16'hFFFF, 1'b1);
        // A zero key is an ordinary name, so the open finds pipe 0.
        issue(CMD_CREATE, 4'd9, '0, '0, 16'hFFFF, 1'b0);
        issue(CMD_OPEN, 4'd0, '0, '0, 16'h0001, 1'b0);
        issue(CMD_OPEN, 4'd15, '1, '1, 16'h1234, 1'b1);
        // Writes and reads on a pipe that was never created.
        issue(CMD_WRITE, 4'd15, '0, 8'hFF, '0, 1'b0);
        issue(CMD_WRITE, 4'd15, '1, 8'h00, '1, 1'b1);
        issue(CMD_READ, 4'd15, '0, '0, '0, 1'b0);
        issue(CMD_READ, 4'd15, '0, '0, '0, 1'b1);
        issue(CMD_READ, 4'd15, '0, '0, '0, 1'b1);
        // Close refused for a stranger, then granted to the owner; reopen reclaims it.
        issue(CMD_CLOSE, 4'd1, '0, '0, 16'hEDCB, 1'b0);
        issue(CMD_CLOSE, 4'd1, '0, '0, 16'h1234, 1'b0);
        issue(CMD_OPEN, 4'd2, '1, '0, 16'h8000, 1'b0);
        issue(CMD_RESERVED_A, '1, '1, '1, '1, 1'b1);
        issue(CMD_RESERVED_B, '0, '0, '0, '0, 1'b0);
        issue(CMD_RESERVED_C, '1, '1, '1, '1, 1'b1);
        issue(CMD_WRITE, 4'd0, {$urandom, $urandom}, 8'hA5, 16'h7FFF, 1'b1);
        issue(CMD_READ, 4'd0, '0, '0, '0, 1'b1);
        issue(CMD_CREATE, 4'd0, 64'h8000_0000_0000_0000, '0, 16'h8000, 1'b0);
        wait_for_results();

        // Random part, built from episodes.
        while (real_items < ITEMS_TARGET)
        begin
            quiet_phase = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (!fill_done && real_items > 300)
            begin
                fill_episode();
                fill_done = 1'b1;
                wait_for_results();
            end
            else if (r < 45)
                stream_episode();
            else if (r < 75)
                table_episode();
            else if (r < 85)
                exhaust_episode();
            else
                noise_episode();
            if ($urandom_range(0, 11) == 0)
                wait_for_results();
        end
        quiet_phase = 1'b0;
        cmd_ch.valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d commands (%0d with a defined code), checked %0d responses.",
                 total_items, real_items, sb.checked);
        $display("Statuses seen: ok %0d, empty %0d, full %0d, no free %0d, refused %0d; wakes %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_NOFREE], sb.status_seen[ST_REFUSED], sb.wakes);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("named_multi_channel_byte_fifo_core regression: pass");
        else
            $display("named_multi_channel_byte_fifo_core regression: fail");
        $finish;
    end

endmodule

FILE: named_multi_channel_byte_fifo_core.f
+incdir+rtl
rtl/nmcbf_pkg.sv
rtl/nmcbf_cmd_if.sv
rtl/nmcbf_rsp_if.sv
rtl/nmcbf_name_table.sv
rtl/nmcbf_desc_mem.sv
rtl/nmcbf_byte_mem.sv
rtl/named_multi_channel_byte_fifo_core.sv
rtl/nmcbf_checker.sv
tb/sv/nmcbf_tb_pkg.sv
tb/sv/named_multi_channel_byte_fifo_core_tb.sv
